[rtl/ums_pkg.sv]
// Shared types, codes and helpers of the mass-storage transport sequencer.
`timescale 1ns / 1ps

package ums_pkg;

  // Bulk-only wrapper constants
  localparam logic [31:0] CSW_SIG     = 32'h5342_5355;
  localparam logic [15:0] CBW_SIZE    = 16'd31;
  localparam logic [15:0] CSW_SIZE    = 16'd13;
  localparam logic [4:0]  CDB_MAX_LEN = 5'd12;
  localparam int unsigned MAX_RES     = 3;

  // Transport kinds (the fourth code behaves as CB)
  localparam logic [1:0] KIND_BOT = 2'd0;
  localparam logic [1:0] KIND_CBI = 2'd1;

  // Configuration register indexes
  localparam logic [1:0] CFG_KIND   = 2'd0;
  localparam logic [1:0] CFG_UFI    = 2'd1;
  localparam logic [1:0] CFG_ENABLE = 2'd2;

  typedef enum logic [1:0] {
    CMD_SUBMIT    = 2'd0,
    CMD_XFER_DONE = 2'd1,
    CMD_CTRL_DONE = 2'd2,
    CMD_ABORT     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    XR_OK    = 2'd0,
    XR_FAIL  = 2'd1,
    XR_STALL = 2'd2,
    XR_RSVD  = 2'd3
  } xres_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_CMD    = 3'd1,
    ST_DATA   = 3'd2,
    ST_STATUS = 3'd3,
    ST_RETRY  = 3'd4
  } stage_e;

  typedef enum logic [1:0] {
    RC_IDLE    = 2'd0,
    RC_RESET   = 2'd1,
    RC_CLR_IN  = 2'd2,
    RC_CLR_OUT = 2'd3
  } recov_e;

  typedef enum logic [2:0] {
    PC_NONE      = 3'd0,
    PC_ADSC      = 3'd1,
    PC_CSW       = 3'd2,
    PC_CSW_RETRY = 3'd3,
    PC_RECOV     = 3'd4
  } pend_e;

  typedef enum logic [3:0] {
    ACT_NONE        = 4'd0,
    ACT_SEND_CBW    = 4'd1,
    ACT_BULK_IN     = 4'd2,
    ACT_BULK_OUT    = 4'd3,
    ACT_READ_CSW    = 4'd4,
    ACT_READ_INTR   = 4'd5,
    ACT_ADSC        = 4'd6,
    ACT_CLR_HALT_IN = 4'd7,
    ACT_CLR_HALT_OUT= 4'd8,
    ACT_MSC_RESET   = 4'd9,
    ACT_SEND_DIAG   = 4'd10,
    ACT_ABORT_EPS   = 4'd11,
    ACT_UNSTALL_IN  = 4'd12,
    ACT_UNSTALL_OUT = 4'd13
  } action_e;

  typedef enum logic [1:0] {
    FS_PASS  = 2'd0,
    FS_FAIL  = 2'd1,
    FS_PHASE = 2'd2
  } fstat_e;

  // One accepted input item
  typedef struct packed {
    cmd_e        cmd;
    logic        from_out_endpoint;
    logic [1:0]  xfer_result;
    logic [15:0] byte_count;
    logic [31:0] length_word;
    logic [31:0] tag_word;
    logic        dir_in;
    logic        has_buffer;
    logic [4:0]  command_length;
    logic [31:0] csw_signature;
    logic [7:0]  status_byte0;
    logic [7:0]  status_byte1;
  } item_t;

  // One result item without the per-step flags
  typedef struct packed {
    action_e     action;
    logic [15:0] len;
    logic        done;
    fstat_e      status;
    logic [31:0] residue;
  } res_t;

  // All results caused by one item
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [1:0]         last_idx;
    logic               ready;
  } bundle_t;

  function automatic res_t act_res(action_e a, logic [15:0] l);
    res_t r;
    r        = '0;
    r.action = a;
    r.len    = l;
    return r;
  endfunction

  function automatic res_t fin_res(fstat_e s, logic [31:0] v);
    res_t r;
    r         = '0;
    r.action  = ACT_NONE;
    r.done    = 1'b1;
    r.status  = s;
    r.residue = v;
    return r;
  endfunction

endpackage

[rtl/ums_in_if.sv]
// Input channel: transfer events and command submissions.
`timescale 1ns / 1ps

interface ums_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        from_out_endpoint;
  logic [1:0]  xfer_result;
  logic [15:0] byte_count;
  logic [31:0] length_word;
  logic [31:0] tag_word;
  logic        dir_in;
  logic        has_buffer;
  logic [4:0]  command_length;
  logic [31:0] csw_signature;
  logic [7:0]  status_byte0;
  logic [7:0]  status_byte1;

  modport source (
    output valid, cmd, from_out_endpoint, xfer_result, byte_count, length_word,
           tag_word, dir_in, has_buffer, command_length, csw_signature,
           status_byte0, status_byte1,
    input  ready
  );

  modport sink (
    input  valid, cmd, from_out_endpoint, xfer_result, byte_count, length_word,
           tag_word, dir_in, has_buffer, command_length, csw_signature,
           status_byte0, status_byte1,
    output ready
  );
endinterface

[rtl/ums_out_if.sv]
// Output channel: transfer actions and command completions.
`timescale 1ns / 1ps

interface ums_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [15:0] action_length;
  logic        done_res;
  logic [1:0]  final_status;
  logic [31:0] final_residue;
  logic        ready_res;
  logic        last;

  modport source (
    output valid, action, action_length, done_res, final_status, final_residue,
           ready_res, last,
    input  ready
  );

  modport sink (
    input  valid, action, action_length, done_res, final_status, final_residue,
           ready_res, last,
    output ready
  );
endinterface

[rtl/ums_step.sv]
// Sequencer state, configuration registers and per-item decision logic.
`timescale 1ns / 1ps

module ums_step import ums_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [1:0] cfg_wdata_i,
  input  item_t      item_i,
  input  logic       fire_i,
  output bundle_t    bundle_o
);

  logic [1:0]  kind_q;
  logic        ufi_q, en_q;
  stage_e      stage_q, stage_d;
  recov_e      rec_q, rec_d;
  pend_e       pend_q, pend_d;
  logic        stalled_q, stalled_d;
  logic [31:0] slen_q, slen_d;
  logic [31:0] stag_q, stag_d;
  logic        sdir_q, sdir_d;
  logic        sbuf_q, sbuf_d;
  logic [31:0] sres_q, sres_d;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_BOT;
      ufi_q  <= 1'b0;
      en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KIND:   kind_q <= cfg_wdata_i;
        CFG_UFI:    ufi_q  <= cfg_wdata_i[0];
        CFG_ENABLE: en_q   <= cfg_wdata_i[0];
        default:    ;
      endcase
    end
  end

  // Decide the actions and next state for the held item
  always_comb begin
    res_t [MAX_RES-1:0] r;
    logic [1:0]  n;
    xres_e       xr;
    stage_e      st;
    logic        bot, intr, do_rec, csw_ok;
    logic [4:0]  clen;
    logic [31:0] resid;
    logic [1:0]  k;
    fstat_e      cst;

    r         = '0;
    n         = 2'd0;
    do_rec    = 1'b0;
    csw_ok    = 1'b0;
    clen      = 5'd0;
    resid     = 32'd0;
    k         = 2'd0;
    cst       = FS_PASS;
    bot       = (kind_q == KIND_BOT);
    intr      = (kind_q == KIND_CBI);
    xr        = (item_i.xfer_result == XR_RSVD) ? XR_FAIL : xres_e'(item_i.xfer_result);
    st        = stage_q;
    stage_d   = stage_q;
    rec_d     = rec_q;
    pend_d    = pend_q;
    stalled_d = stalled_q;
    slen_d    = slen_q;
    stag_d    = stag_q;
    sdir_d    = sdir_q;
    sbuf_d    = sbuf_q;
    sres_d    = sres_q;

    unique case (item_i.cmd)
      CMD_SUBMIT: begin
        if (en_q && stage_q == ST_IDLE && rec_q == RC_IDLE) begin
          slen_d    = item_i.length_word;
          stag_d    = item_i.tag_word;
          sdir_d    = item_i.dir_in;
          sbuf_d    = item_i.has_buffer;
          stalled_d = 1'b0;
          stage_d   = ST_CMD;
          if (bot) begin
            r[n] = act_res(ACT_SEND_CBW, 16'd0); n = n + 2'd1;
          end else begin
            clen   = (item_i.command_length > CDB_MAX_LEN) ? CDB_MAX_LEN :
                     item_i.command_length;
            pend_d = PC_ADSC;
            r[n] = act_res(ACT_ADSC, {11'd0, ufi_q ? CDB_MAX_LEN : clen}); n = n + 2'd1;
          end
        end
      end

      CMD_XFER_DONE: begin
        if (bot) begin
          // Command block phase, may fall through to an empty data phase
          if (st == ST_CMD) begin
            if (!item_i.from_out_endpoint || xr != XR_OK || item_i.byte_count != CBW_SIZE) begin
              stage_d = ST_IDLE;
              r[n] = fin_res(FS_FAIL, slen_q); n = n + 2'd1;
              st = ST_IDLE;
            end else if (slen_q != 32'd0 && sbuf_q) begin
              if (slen_q > 32'h0000_FFFF) begin
                stage_d = ST_IDLE;
                r[n] = fin_res(FS_FAIL, slen_q); n = n + 2'd1;
              end else begin
                stage_d = ST_DATA;
                r[n] = act_res(sdir_q ? ACT_BULK_IN : ACT_BULK_OUT, slen_q[15:0]);
                n = n + 2'd1;
              end
              st = ST_IDLE;
            end else begin
              st = ST_DATA;
            end
          end
          // Data phase ends: read the status wrapper, clearing a stall first
          if (st == ST_DATA) begin
            stage_d = ST_STATUS;
            if (xr == XR_STALL) begin
              r[n] = act_res(sdir_q ? ACT_UNSTALL_IN : ACT_UNSTALL_OUT, 16'd0); n = n + 2'd1;
              r[n] = act_res(sdir_q ? ACT_CLR_HALT_IN : ACT_CLR_HALT_OUT, 16'd0);
              n = n + 2'd1;
              pend_d = PC_CSW;
            end else begin
              r[n] = act_res(ACT_READ_CSW, 16'd0); n = n + 2'd1;
            end
          end else if (st == ST_STATUS && xr == XR_OK && item_i.byte_count == 16'd0) begin
            stage_d = ST_RETRY;
            r[n] = act_res(ACT_READ_CSW, 16'd0); n = n + 2'd1;
          end else if (st == ST_STATUS && xr == XR_STALL) begin
            stage_d = ST_RETRY;
            r[n] = act_res(ACT_UNSTALL_IN, 16'd0); n = n + 2'd1;
            r[n] = act_res(ACT_CLR_HALT_IN, 16'd0); n = n + 2'd1;
            pend_d = PC_CSW_RETRY;
          end else if (st == ST_STATUS || st == ST_RETRY) begin
            // Validate the status wrapper
            csw_ok = xr == XR_OK && item_i.byte_count == CSW_SIZE &&
                     item_i.csw_signature == CSW_SIG && item_i.tag_word == stag_q &&
                     item_i.length_word <= slen_q && item_i.status_byte0 <= 8'd2;
            stage_d = ST_IDLE;
            if (!csw_ok) begin
              r[n] = fin_res(FS_FAIL, slen_q); n = n + 2'd1;
              do_rec = 1'b1;
            end else begin
              r[n] = fin_res(fstat_e'(item_i.status_byte0[1:0]), item_i.length_word);
              n = n + 2'd1;
              do_rec = (item_i.status_byte0[1:0] == FS_PHASE);
            end
          end
        end else begin
          if (stage_q == ST_DATA) begin
            resid = ({16'd0, item_i.byte_count} <= slen_q) ?
                    slen_q - {16'd0, item_i.byte_count} : 32'd0;
            if (xr == XR_STALL) begin
              r[n] = act_res(sdir_q ? ACT_UNSTALL_IN : ACT_UNSTALL_OUT, 16'd0); n = n + 2'd1;
              stalled_d = 1'b1;
            end
            if (intr) begin
              sres_d  = resid;
              stage_d = ST_STATUS;
              r[n] = act_res(ACT_READ_INTR, 16'd0); n = n + 2'd1;
            end else begin
              stage_d = ST_IDLE;
              r[n] = fin_res((xr == XR_OK) ? FS_PASS : FS_FAIL, resid); n = n + 2'd1;
              do_rec = (xr != XR_OK);
            end
          end else if (stage_q == ST_STATUS) begin
            // Decode the interrupt status block
            k = item_i.status_byte1[1:0];
            if (xr != XR_OK || item_i.byte_count < 16'd2) begin
              cst = FS_FAIL;
            end else if (ufi_q) begin
              cst = (item_i.status_byte0 == 8'd0 && item_i.status_byte1 == 8'd0) ?
                    FS_PASS : FS_FAIL;
            end else if (item_i.status_byte0 != 8'd0) begin
              cst = FS_FAIL;
            end else begin
              cst = (k == 2'd0) ? FS_PASS : ((k == 2'd1) ? FS_FAIL : FS_PHASE);
            end
            stage_d = ST_IDLE;
            r[n] = fin_res(cst, sres_q); n = n + 2'd1;
            do_rec = (cst == FS_PHASE) || stalled_q;
          end
        end
      end

      CMD_CTRL_DONE: begin
        unique case (pend_q)
          PC_NONE: ;
          PC_RECOV: begin
            // Advance reset recovery
            if (xr != XR_OK) begin
              if (rec_q == RC_CLR_IN || rec_q == RC_CLR_OUT) begin
                if (rec_q == RC_CLR_IN) begin
                  r[n] = act_res(ACT_UNSTALL_IN, 16'd0); n = n + 2'd1;
                end
                r[n] = act_res(ACT_UNSTALL_OUT, 16'd0); n = n + 2'd1;
                rec_d  = RC_IDLE;
                pend_d = PC_NONE;
              end else begin
                rec_d = RC_CLR_IN;
                r[n] = act_res(ACT_CLR_HALT_IN, 16'd0); n = n + 2'd1;
              end
            end else if (rec_q == RC_RESET) begin
              rec_d = RC_CLR_IN;
              r[n] = act_res(ACT_CLR_HALT_IN, 16'd0); n = n + 2'd1;
            end else if (rec_q == RC_CLR_IN) begin
              r[n] = act_res(ACT_UNSTALL_IN, 16'd0); n = n + 2'd1;
              rec_d = RC_CLR_OUT;
              r[n] = act_res(ACT_CLR_HALT_OUT, 16'd0); n = n + 2'd1;
            end else begin
              if (rec_q == RC_CLR_OUT) begin
                r[n] = act_res(ACT_UNSTALL_OUT, 16'd0); n = n + 2'd1;
              end
              rec_d  = RC_IDLE;
              pend_d = PC_NONE;
            end
          end
          PC_CSW, PC_CSW_RETRY: begin
            pend_d  = PC_NONE;
            stage_d = (pend_q == PC_CSW_RETRY) ? ST_RETRY : ST_STATUS;
            r[n] = act_res(ACT_READ_CSW, 16'd0); n = n + 2'd1;
          end
          default: begin
            // Command block sent by control transfer
            pend_d = PC_NONE;
            if (xr != XR_OK) begin
              stage_d = ST_IDLE;
              r[n] = fin_res(FS_FAIL, slen_q); n = n + 2'd1;
            end else if (slen_q != 32'd0 && sbuf_q) begin
              if (slen_q > 32'h0000_FFFF) begin
                stage_d = ST_IDLE;
                r[n] = fin_res(FS_FAIL, slen_q); n = n + 2'd1;
              end else begin
                stage_d = ST_DATA;
                r[n] = act_res(sdir_q ? ACT_BULK_IN : ACT_BULK_OUT, slen_q[15:0]);
                n = n + 2'd1;
              end
            end else if (intr) begin
              sres_d  = 32'd0;
              stage_d = ST_STATUS;
              r[n] = act_res(ACT_READ_INTR, 16'd0); n = n + 2'd1;
            end else begin
              stage_d = ST_IDLE;
              r[n] = fin_res(FS_PASS, 32'd0); n = n + 2'd1;
            end
          end
        endcase
      end

      CMD_ABORT: begin
        if (en_q) begin
          if (rec_q != RC_IDLE) begin
            r[n] = act_res(ACT_ABORT_EPS, 16'd0); n = n + 2'd1;
            rec_d  = RC_IDLE;
            pend_d = PC_NONE;
          end else if (stage_q != ST_IDLE) begin
            r[n] = act_res(ACT_ABORT_EPS, 16'd0); n = n + 2'd1;
            stage_d = ST_IDLE;
            pend_d  = PC_NONE;
            do_rec  = 1'b1;
          end
        end
      end

      default: ;
    endcase

    // Start reset recovery after the step's other actions
    if (do_rec && en_q && rec_d == RC_IDLE) begin
      rec_d  = RC_RESET;
      pend_d = PC_RECOV;
      if (bot) begin
        r[n] = act_res(ACT_MSC_RESET, 16'd0);
      end else begin
        r[n] = act_res(ACT_SEND_DIAG, {11'd0, CDB_MAX_LEN});
      end
      n = n + 2'd1;
    end

    // A step always answers with at least one item
    if (n == 2'd0) begin
      r[0] = act_res(ACT_NONE, 16'd0);
      n    = 2'd1;
    end

    bundle_o.res      = r;
    bundle_o.last_idx = n - 2'd1;
    bundle_o.ready    = en_q && stage_d == ST_IDLE && rec_d == RC_IDLE;
  end

  // Commit state when the item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q   <= ST_IDLE;
      rec_q     <= RC_IDLE;
      pend_q    <= PC_NONE;
      stalled_q <= 1'b0;
      slen_q    <= 32'd0;
      stag_q    <= 32'd0;
      sdir_q    <= 1'b0;
      sbuf_q    <= 1'b0;
      sres_q    <= 32'd0;
    end else if (fire_i) begin
      stage_q   <= stage_d;
      rec_q     <= rec_d;
      pend_q    <= pend_d;
      stalled_q <= stalled_d;
      slen_q    <= slen_d;
      stag_q    <= stag_d;
      sdir_q    <= sdir_d;
      sbuf_q    <= sbuf_d;
      sres_q    <= sres_d;
    end
  end

endmodule

[rtl/ums_emit.sv]
// Result register: holds one item's results and hands them out one by one.
`timescale 1ns / 1ps

module ums_emit import ums_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  bundle_t bundle_i,
  input  logic    load_i,
  output logic    free_o,
  ums_out_if.source out_o
);

  logic       valid_q;
  bundle_t    bundle_q;
  logic [1:0] idx_q;
  logic       is_last, pop;
  res_t       cur;

  assign cur     = bundle_q.res[idx_q];
  assign is_last = (idx_q == bundle_q.last_idx);
  assign pop     = valid_q && out_o.ready;
  assign free_o  = !valid_q || (pop && is_last);

  // Load a new set of results or advance through the held one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= 2'd0;
    end else if (pop) begin
      if (is_last) begin
        valid_q <= 1'b0;
        idx_q   <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

  // Drive the output item
  assign out_o.valid         = valid_q;
  assign out_o.action        = cur.action;
  assign out_o.action_length = cur.len;
  assign out_o.done_res      = cur.done;
  assign out_o.final_status  = cur.status;
  assign out_o.final_residue = cur.residue;
  assign out_o.ready_res     = bundle_q.ready;
  assign out_o.last          = is_last;

endmodule

[rtl/usb_msc_transport_sequencer.sv]
// Top level of the host-side USB mass-storage transport sequencer.
//
//   channel    direction  carries
//   in_ch_i    in         submit, transfer done, control done and abort events
//   out_ch_o   out        transfer actions, completions with status and residue
//   cfg_*_i    in         transport kind, UFI subclass and enable writes
//
// An event is taken into an input register and decided combinationally; its one to
// three results then leave from the result register at one per cycle while the output is ready.
// A new event is accepted every cycle while each yields a single result and the output is ready;
// an event with more results holds the input side until its last result is taken.
// Reset clears all state and configuration; no clearing pass is needed.
// A stalled output holds the result register, then the input register, then ready.
`timescale 1ns / 1ps

module usb_msc_transport_sequencer import ums_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [1:0] cfg_wdata_i,
  ums_in_if.sink     in_ch_i,
  ums_out_if.source  out_ch_o
);

  logic    inq_valid_q;
  item_t   inq_q;
  logic    fire, emit_free;
  bundle_t bundle;

  assign fire           = inq_valid_q && emit_free;
  assign in_ch_i.ready  = !inq_valid_q || fire;

  // Hold the accepted item until its results can be registered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_ch_i.ready) begin
      inq_valid_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch_i.valid && in_ch_i.ready) begin
      inq_q.cmd               <= cmd_e'(in_ch_i.cmd);
      inq_q.from_out_endpoint <= in_ch_i.from_out_endpoint;
      inq_q.xfer_result       <= in_ch_i.xfer_result;
      inq_q.byte_count        <= in_ch_i.byte_count;
      inq_q.length_word       <= in_ch_i.length_word;
      inq_q.tag_word          <= in_ch_i.tag_word;
      inq_q.dir_in            <= in_ch_i.dir_in;
      inq_q.has_buffer        <= in_ch_i.has_buffer;
      inq_q.command_length    <= in_ch_i.command_length;
      inq_q.csw_signature     <= in_ch_i.csw_signature;
      inq_q.status_byte0      <= in_ch_i.status_byte0;
      inq_q.status_byte1      <= in_ch_i.status_byte1;
    end
  end

  ums_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (inq_q),
    .fire_i      (fire),
    .bundle_o    (bundle)
  );

  ums_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bundle_i (bundle),
    .load_i   (fire),
    .free_o   (emit_free),
    .out_o    (out_ch_o)
  );

endmodule

[verif/tb.sv]
// Self-checking testbench for the USB mass-storage transport sequencer.
`timescale 1ns / 1ps

module tb;
  import ums_pkg::*;

  // Control-bulk transport codes; the fourth code must act like the third
  localparam logic [1:0] KIND_CB      = 2'd2;
  localparam logic [1:0] KIND_CB_ALT  = 2'd3;
  localparam int unsigned STALL_LIMIT = 500;
  localparam int unsigned PHASES      = 6;

  localparam logic [1:0] PHASE_KIND [PHASES] = '{KIND_BOT, KIND_CBI, KIND_CB, KIND_CB_ALT,
                                                 KIND_CBI, KIND_BOT};
  localparam logic [1:0] PHASE_UFI  [PHASES] = '{2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1};

  // One expected or observed result item with its per-step flags
  typedef struct {
    res_t r;
    logic ready;
    logic last;
  } outcome_t;

  // Tracks the sequencer's state and keeps the results it still owes
  class transport_tracker;
    logic [1:0]  kind = '0;
    logic        ufi  = 1'b0;
    logic        en   = 1'b0;
    stage_e      stage = ST_IDLE;
    recov_e      recov = RC_IDLE;
    pend_e       pend  = PC_NONE;
    logic        stalled = 1'b0;
    logic [31:0] exp_len = '0;
    logic [31:0] tag = '0;
    logic [31:0] residue = '0;
    logic        dir_in = 1'b0;
    logic        has_buf = 1'b0;
    res_t        step_q[$];
    outcome_t    due[$];
    int unsigned errors = 0;

    function void set_reg(logic [1:0] idx, logic [1:0] val);
      case (idx)
        CFG_KIND:   kind = val;
        CFG_UFI:    ufi  = val[0];
        CFG_ENABLE: en   = val[0];
        default: ;
      endcase
    endfunction

    function void emit_action(action_e a, logic [15:0] l);
      res_t r;
      r        = '0;
      r.action = a;
      r.len    = l;
      step_q.push_back(r);
    endfunction

    function void complete(fstat_e s, logic [31:0] v);
      res_t r;
      stage     = ST_IDLE;
      r         = '0;
      r.action  = ACT_NONE;
      r.done    = 1'b1;
      r.status  = s;
      r.residue = v;
      step_q.push_back(r);
    endfunction

    function void begin_recovery();
      if (!en || recov != RC_IDLE) return;
      recov = RC_RESET;
      pend  = PC_RECOV;
      if (kind == KIND_BOT) emit_action(ACT_MSC_RESET, 16'd0);
      else emit_action(ACT_SEND_DIAG, 16'(CDB_MAX_LEN));
    endfunction

    function void begin_data();
      if (exp_len > 32'h0000_FFFF) begin
        complete(FS_FAIL, exp_len);
        return;
      end
      stage = ST_DATA;
      emit_action(dir_in ? ACT_BULK_IN : ACT_BULK_OUT, exp_len[15:0]);
    endfunction

    // Walk reset, clear IN halt, clear OUT halt; a failed clear ends the walk
    function void recovery_step(logic [1:0] r);
      if (r != XR_OK) begin
        if (recov == RC_CLR_IN || recov == RC_CLR_OUT) begin
          if (recov == RC_CLR_IN) emit_action(ACT_UNSTALL_IN, 16'd0);
          emit_action(ACT_UNSTALL_OUT, 16'd0);
          recov = RC_IDLE;
          pend  = PC_NONE;
          return;
        end
        recov = RC_CLR_IN;
        emit_action(ACT_CLR_HALT_IN, 16'd0);
        return;
      end
      if (recov == RC_RESET) begin
        recov = RC_CLR_IN;
        emit_action(ACT_CLR_HALT_IN, 16'd0);
      end else if (recov == RC_CLR_IN) begin
        emit_action(ACT_UNSTALL_IN, 16'd0);
        recov = RC_CLR_OUT;
        emit_action(ACT_CLR_HALT_OUT, 16'd0);
      end else begin
        if (recov == RC_CLR_OUT) emit_action(ACT_UNSTALL_OUT, 16'd0);
        recov = RC_IDLE;
        pend  = PC_NONE;
      end
    endfunction

    function void control_step(logic [1:0] r);
      pend_e p;
      p = pend;
      if (p == PC_RECOV) begin
        recovery_step(r);
        return;
      end
      if (p == PC_NONE) return;
      pend = PC_NONE;
      if (p == PC_CSW || p == PC_CSW_RETRY) begin
        stage = (p == PC_CSW_RETRY) ? ST_RETRY : ST_STATUS;
        emit_action(ACT_READ_CSW, 16'd0);
        return;
      end
      if (r != XR_OK) begin
        complete(FS_FAIL, exp_len);
        return;
      end
      if (exp_len != 0 && has_buf) begin_data();
      else if (kind == KIND_CBI) begin
        residue = '0;
        stage   = ST_STATUS;
        emit_action(ACT_READ_INTR, 16'd0);
      end else complete(FS_PASS, 32'd0);
    endfunction

    // Bulk-only: CBW, data, then CSW with one re-read
    function void bulk_only_step(item_t ev, logic [1:0] r);
      stage_e st;
      logic   ok;
      st = stage;
      if (st == ST_CMD) begin
        if (!ev.from_out_endpoint || r != XR_OK || ev.byte_count != CBW_SIZE) begin
          complete(FS_FAIL, exp_len);
          return;
        end
        if (exp_len != 0 && has_buf) begin
          begin_data();
          return;
        end
        st = ST_DATA;
      end
      if (st == ST_DATA) begin
        stage = ST_STATUS;
        if (r == XR_STALL) begin
          emit_action(dir_in ? ACT_UNSTALL_IN : ACT_UNSTALL_OUT, 16'd0);
          emit_action(dir_in ? ACT_CLR_HALT_IN : ACT_CLR_HALT_OUT, 16'd0);
          pend = PC_CSW;
        end else emit_action(ACT_READ_CSW, 16'd0);
        return;
      end
      if (st == ST_STATUS || st == ST_RETRY) begin
        if (st == ST_STATUS) begin
          if (r == XR_OK && ev.byte_count == 16'd0) begin
            stage = ST_RETRY;
            emit_action(ACT_READ_CSW, 16'd0);
            return;
          end
          if (r == XR_STALL) begin
            stage = ST_RETRY;
            emit_action(ACT_UNSTALL_IN, 16'd0);
            emit_action(ACT_CLR_HALT_IN, 16'd0);
            pend = PC_CSW_RETRY;
            return;
          end
        end
        ok = r == XR_OK && ev.byte_count == CSW_SIZE && ev.csw_signature == CSW_SIG &&
             ev.tag_word == tag && ev.length_word <= exp_len && ev.status_byte0 <= 8'd2;
        if (!ok) begin
          complete(FS_FAIL, exp_len);
          begin_recovery();
        end else begin
          complete(fstat_e'(ev.status_byte0[1:0]), ev.length_word);
          if (ev.status_byte0 == 8'd2) begin_recovery();
        end
      end
    endfunction

    // CBI/CB: data completion, then interrupt status where there is one
    function void cbi_step(item_t ev, logic [1:0] r);
      logic [31:0] left;
      fstat_e      s;
      if (stage == ST_DATA) begin
        left = ({16'd0, ev.byte_count} <= exp_len) ? exp_len - {16'd0, ev.byte_count} :
               32'd0;
        if (r == XR_STALL) begin
          emit_action(dir_in ? ACT_UNSTALL_IN : ACT_UNSTALL_OUT, 16'd0);
          stalled = 1'b1;
        end
        if (kind == KIND_CBI) begin
          residue = left;
          stage   = ST_STATUS;
          emit_action(ACT_READ_INTR, 16'd0);
        end else begin
          complete((r == XR_OK) ? FS_PASS : FS_FAIL, left);
          if (r != XR_OK) begin_recovery();
        end
      end else if (stage == ST_STATUS) begin
        if (r != XR_OK || ev.byte_count < 16'd2) s = FS_FAIL;
        else if (ufi) begin
          s = (ev.status_byte0 == 8'd0 && ev.status_byte1 == 8'd0) ? FS_PASS : FS_FAIL;
        end
        else if (ev.status_byte0 != 8'd0) s = FS_FAIL;
        else begin
          case (ev.status_byte1[1:0])
            2'd0:    s = FS_PASS;
            2'd1:    s = FS_FAIL;
            default: s = FS_PHASE;
          endcase
        end
        complete(s, residue);
        if (s == FS_PHASE || stalled) begin_recovery();
      end
    endfunction

    function void submit_step(item_t ev);
      logic [4:0] clen;
      if (!en || stage != ST_IDLE || recov != RC_IDLE) return;
      exp_len = ev.length_word;
      tag     = ev.tag_word;
      dir_in  = ev.dir_in;
      has_buf = ev.has_buffer;
      stalled = 1'b0;
      stage   = ST_CMD;
      if (kind == KIND_BOT) begin
        emit_action(ACT_SEND_CBW, 16'd0);
        return;
      end
      clen = (ev.command_length > CDB_MAX_LEN) ? CDB_MAX_LEN : ev.command_length;
      pend = PC_ADSC;
      emit_action(ACT_ADSC, ufi ? 16'(CDB_MAX_LEN) : 16'(clen));
    endfunction

    function void abort_step();
      if (!en) return;
      if (recov != RC_IDLE) begin
        emit_action(ACT_ABORT_EPS, 16'd0);
        recov = RC_IDLE;
        pend  = PC_NONE;
        return;
      end
      if (stage == ST_IDLE) return;
      emit_action(ACT_ABORT_EPS, 16'd0);
      stage = ST_IDLE;
      pend  = PC_NONE;
      begin_recovery();
    endfunction

    // Advance the state for one accepted item and queue what it must produce
    function void note_event(item_t ev);
      logic [1:0] r;
      logic       rdy;
      outcome_t   o;
      r = (ev.xfer_result == XR_RSVD) ? XR_FAIL : ev.xfer_result;
      step_q.delete();
      case (ev.cmd)
        CMD_SUBMIT:    submit_step(ev);
        CMD_XFER_DONE: if (kind == KIND_BOT) bulk_only_step(ev, r); else cbi_step(ev, r);
        CMD_CTRL_DONE: control_step(r);
        default:       abort_step();
      endcase
      if (step_q.size() == 0) emit_action(ACT_NONE, 16'd0);
      rdy = en && stage == ST_IDLE && recov == RC_IDLE;
      foreach (step_q[k]) begin
        o.r     = step_q[k];
        o.ready = rdy;
        o.last  = (k == step_q.size() - 1);
        due.push_back(o);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (due.size() == 0) begin
        $error("action: expected no item, got 0x%0h", got.r.action);
        errors++;
        return;
      end
      want = due.pop_front();
      compare_field("action", 32'(want.r.action), 32'(got.r.action));
      compare_field("action_length", 32'(want.r.len), 32'(got.r.len));
      compare_field("done_res", 32'(want.r.done), 32'(got.r.done));
      compare_field("final_status", 32'(want.r.status), 32'(got.r.status));
      compare_field("final_residue", want.r.residue, got.r.residue);
      compare_field("ready_res", 32'(want.ready), 32'(got.ready));
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [1:0]  cfg_wdata;
  bit          calm = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned quiet_cycles = 0;
  outcome_t    seen;

  transport_tracker tracker = new;

  ums_in_if  ev_ch ();
  ums_out_if act_ch ();

  usb_msc_transport_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_ch_i     (ev_ch),
    .out_ch_o    (act_ch)
  );

  always #5 clk_i = ~clk_i;

  // Stall the result side in random bursts
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      act_ch.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      act_ch.ready <= 1'b0;
      hold_cycles  <= $urandom_range(0, 6);
    end else begin
      act_ch.ready <= 1'b1;
    end
  end

  // Check every accepted result against the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && act_ch.valid && act_ch.ready) begin
      seen.r.action  = action_e'(act_ch.action);
      seen.r.len     = act_ch.action_length;
      seen.r.done    = act_ch.done_res;
      seen.r.status  = fstat_e'(act_ch.final_status);
      seen.r.residue = act_ch.final_residue;
      seen.ready     = act_ch.ready_res;
      seen.last      = act_ch.last;
      tracker.check_result(seen);
    end
  end

  // Drop the run if nothing moves on either side for too long
  always @(posedge clk_i) begin
    if ((ev_ch.valid && ev_ch.ready) || (act_ch.valid && act_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t random_event();
    item_t ev;
    ev.cmd               = cmd_e'($urandom_range(0, 3));
    ev.from_out_endpoint = 1'($urandom_range(0, 1));
    ev.xfer_result       = 2'($urandom_range(0, 3));
    ev.byte_count        = 16'($urandom_range(0, 65535));
    ev.length_word       = $urandom;
    ev.tag_word          = $urandom;
    ev.dir_in            = 1'($urandom_range(0, 1));
    ev.has_buffer        = 1'($urandom_range(0, 1));
    ev.command_length    = 5'($urandom_range(0, 31));
    ev.csw_signature     = $urandom;
    ev.status_byte0      = 8'($urandom_range(0, 255));
    ev.status_byte1      = 8'($urandom_range(0, 255));
    return ev;
  endfunction

  // Pick the event a real device would most likely report next
  function automatic item_t plausible_event();
    item_t       ev;
    int unsigned k;
    int unsigned j;
    ev = random_event();
    k  = $urandom_range(0, 9);
    j  = $urandom_range(0, 9);
    ev.xfer_result = (k < 7) ? XR_OK : 2'(k - 6);
    if ($urandom_range(0, 24) == 0) ev.cmd = CMD_ABORT;
    else if (tracker.recov != RC_IDLE) ev.cmd = CMD_CTRL_DONE;
    else if (tracker.stage == ST_IDLE) begin
      ev.cmd            = CMD_SUBMIT;
      ev.has_buffer     = (j < 8);
      ev.command_length = 5'($urandom_range(0, 16));
      if (j < 6) ev.length_word = $urandom_range(0, 64);
      else if (j < 8) ev.length_word = $urandom_range(0, 65535);
      else if (j == 8) ev.length_word = 32'd0;
    end else if (tracker.pend != PC_NONE) ev.cmd = CMD_CTRL_DONE;
    else begin
      ev.cmd = CMD_XFER_DONE;
      case (tracker.stage)
        ST_CMD: begin
          ev.from_out_endpoint = (j != 0);
          if (j < 9) ev.byte_count = CBW_SIZE;
        end
        ST_DATA: begin
          if (j < 8) ev.byte_count = 16'($urandom_range(0, tracker.exp_len[15:0]));
        end
        default: begin
          if (tracker.kind == KIND_BOT) begin
            if (j < 7) ev.byte_count = CSW_SIZE;
            else if (j == 7) ev.byte_count = 16'd0;
            if (k != 9) ev.csw_signature = CSW_SIG;
            if (j != 9) ev.tag_word = tracker.tag;
            if (k < 8) ev.length_word = $urandom_range(0, tracker.exp_len);
            if (j < 8) ev.status_byte0 = 8'($urandom_range(0, 2));
          end else begin
            if (j < 8) ev.byte_count = 16'd2;
            if (k < 7) ev.status_byte0 = 8'd0;
            if (j < 7) ev.status_byte1 = 8'($urandom_range(0, 3));
          end
        end
      endcase
    end
    return ev;
  endfunction

  function automatic item_t mk_submit(logic [31:0] len, logic [31:0] t, logic d, logic b,
                                      logic [4:0] clen);
    item_t ev;
    ev                = random_event();
    ev.cmd            = CMD_SUBMIT;
    ev.length_word    = len;
    ev.tag_word       = t;
    ev.dir_in         = d;
    ev.has_buffer     = b;
    ev.command_length = clen;
    return ev;
  endfunction

  function automatic item_t mk_xfer(logic from_out, logic [1:0] r, logic [15:0] count);
    item_t ev;
    ev                   = random_event();
    ev.cmd               = CMD_XFER_DONE;
    ev.from_out_endpoint = from_out;
    ev.xfer_result       = r;
    ev.byte_count        = count;
    return ev;
  endfunction

  function automatic item_t mk_csw(logic [15:0] count, logic [31:0] t, logic [31:0] left,
                                   logic [7:0] st);
    item_t ev;
    ev               = mk_xfer(1'b0, XR_OK, count);
    ev.csw_signature = CSW_SIG;
    ev.tag_word      = t;
    ev.length_word   = left;
    ev.status_byte0  = st;
    return ev;
  endfunction

  function automatic item_t mk_ctrl(logic [1:0] r);
    item_t ev;
    ev             = random_event();
    ev.cmd         = CMD_CTRL_DONE;
    ev.xfer_result = r;
    return ev;
  endfunction

  function automatic item_t mk_abort();
    item_t ev;
    ev     = random_event();
    ev.cmd = CMD_ABORT;
    return ev;
  endfunction

  // Present one item, hold it until taken, then note it and maybe pause
  task automatic issue(input item_t ev);
    ev_ch.valid             <= 1'b1;
    ev_ch.cmd               <= ev.cmd;
    ev_ch.from_out_endpoint <= ev.from_out_endpoint;
    ev_ch.xfer_result       <= ev.xfer_result;
    ev_ch.byte_count        <= ev.byte_count;
    ev_ch.length_word       <= ev.length_word;
    ev_ch.tag_word          <= ev.tag_word;
    ev_ch.dir_in            <= ev.dir_in;
    ev_ch.has_buffer        <= ev.has_buffer;
    ev_ch.command_length    <= ev.command_length;
    ev_ch.csw_signature     <= ev.csw_signature;
    ev_ch.status_byte0      <= ev.status_byte0;
    ev_ch.status_byte1      <= ev.status_byte1;
    do @(posedge clk_i); while (!ev_ch.ready);
    tracker.note_event(ev);
    if (!calm && $urandom_range(0, 3) == 0) begin
      ev_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Drain all owed results, let the pipeline settle, then write one register
  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    ev_ch.valid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    tracker.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    ev_ch.valid             <= 1'b0;
    ev_ch.cmd               <= CMD_SUBMIT;
    ev_ch.from_out_endpoint <= 1'b0;
    ev_ch.xfer_result       <= XR_OK;
    ev_ch.byte_count        <= '0;
    ev_ch.length_word       <= '0;
    ev_ch.tag_word          <= '0;
    ev_ch.dir_in            <= 1'b0;
    ev_ch.has_buffer        <= 1'b0;
    ev_ch.command_length    <= '0;
    ev_ch.csw_signature     <= '0;
    ev_ch.status_byte0      <= '0;
    ev_ch.status_byte1      <= '0;
    cfg_we                  <= 1'b0;
    cfg_idx                 <= CFG_KIND;
    cfg_wdata               <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Disabled device: submit and abort are both dropped
    issue(mk_submit(32'd8, 32'd1, 1'b1, 1'b1, 5'd16));
    issue(mk_abort());
    write_reg(CFG_ENABLE, 2'd1);

    // Stray completions while idle, then an oversized bulk-only command
    issue(mk_xfer(1'b1, XR_OK, CBW_SIZE));
    issue(mk_ctrl(XR_OK));
    issue(mk_submit(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 5'd31));
    issue(mk_submit(32'd4, 32'd0, 1'b0, 1'b1, 5'd0));
    issue(mk_xfer(1'b1, XR_OK, CBW_SIZE));

    // Stalled data, zero-length CSW, then a CSW with a reserved status
    issue(mk_submit(32'd16, 32'hA5A5_5A5A, 1'b1, 1'b1, 5'd12));
    issue(mk_xfer(1'b1, XR_OK, CBW_SIZE));
    issue(mk_xfer(1'b0, XR_STALL, 16'hFFFF));
    issue(mk_ctrl(XR_OK));
    issue(mk_csw(16'd0, 32'hA5A5_5A5A, 32'd0, 8'd0));
    issue(mk_csw(CSW_SIZE, 32'hA5A5_5A5A, 32'd4, 8'hFF));
    issue(mk_ctrl(XR_OK));
    issue(mk_abort());

    // No data phase, phase error, then a full recovery ending in a failed clear
    issue(mk_submit(32'd0, 32'd0, 1'b0, 1'b0, 5'd0));
    issue(mk_xfer(1'b1, XR_OK, CBW_SIZE));
    issue(mk_csw(CSW_SIZE, 32'd0, 32'd0, 8'd2));
    issue(mk_ctrl(XR_OK));
    issue(mk_ctrl(XR_OK));
    issue(mk_ctrl(XR_RSVD));

    // CBI: long command block, abort mid-command, stalled diagnostic
    write_reg(CFG_KIND, KIND_CBI);
    issue(mk_submit(32'd8, 32'd3, 1'b0, 1'b1, 5'd16));
    issue(mk_abort());
    issue(mk_ctrl(XR_STALL));

    // Random phases across transport kinds and subclasses
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_KIND, PHASE_KIND[p]);
      write_reg(CFG_UFI, PHASE_UFI[p]);
      if (p == 3) begin
        write_reg(CFG_ENABLE, 2'd0);
        repeat (5) issue(plausible_event());
        write_reg(CFG_ENABLE, 2'd1);
      end
      calm = (p == PHASES - 1);
      repeat (22) issue(($urandom_range(0, 99) < 85) ? plausible_event() : random_event());
    end

    // Wait out the remaining results, then a short tail for strays
    ev_ch.valid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
